/* src/lzw_vwd_pkg.sv */
// ----------------------------------------------------------------------------
// lzw_vwd_pkg
// Shared constants for the variable-width LZW decoder and its checker.
// ----------------------------------------------------------------------------
package lzw_vwd_pkg;

   localparam int DICT_WORDS   = 4096;
   localparam int STACK_DEPTH  = 255;
   localparam int WINDOW_BYTES = 1024;
   localparam int DICT_LIMIT   = 768 * 16;

   localparam logic [11:0] CODE_CLEAR      = 12'h100;
   localparam logic [11:0] CODE_END        = 12'h101;
   localparam logic [13:0] FIRST_FREE      = 14'h102;
   localparam logic [12:0] FIRST_THRESHOLD = 13'h200;
   localparam logic [3:0]  FIRST_WIDTH     = 4'd9;
   localparam logic [3:0]  MAX_WIDTH       = 4'd12;

   typedef enum logic [1:0] {
      ST_DATA     = 2'd0,
      ST_END      = 2'd1,
      ST_OVERFLOW = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

endpackage

/* src/lzw_variable_width_decoder.sv */
// A byte that completes no code is only loaded. A dictionary code walks its
// prefix chain onto the stack, then pops and packs the bytes into result words,
// holding on rsp_stall; a literal after clear and the end code go straight out.
// One byte is taken at a time; req_stall stays high until that byte's work is done.
// Reset (synchronous, active high) clears all control state; dictionary and
// stack contents are undefined until written.
// ----------------------------------------------------------------------------
// lzw_variable_width_decoder
// Unpacks LSB-first 9 to 12 bit LZW codes and emits decoded bytes, four to a
// word, walking the prefix chain with a small sequencer.
// ----------------------------------------------------------------------------
module lzw_variable_width_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_stream_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_out_bytes,
   output logic [2:0]  rsp_byte_count,
   output logic [1:0]  rsp_status,
   output logic        rsp_last_of_run
);

   typedef enum logic [3:0] {
      S_IDLE, S_LOAD, S_EXTRACT, S_DECODE, S_WALK, S_WREAD,
      S_UPDATE, S_POP, S_PACK, S_OUT
   } state_type;

   state_type   state_ff;
   logic [7:0]  byte_ff;
   logic [23:0] acc_ff;
   logic [4:0]  held_ff;
   logic [2:0]  first_bit_ff;
   logic [3:0]  width_ff;
   logic [13:0] next_code_ff;
   logic [12:0] threshold_ff;
   logic [11:0] prev_code_ff;
   logic [7:0]  prev_char_ff;
   logic        after_clear_ff;
   logic [9:0]  window_ff;
   logic        stopped_ff;
   logic [11:0] code_ff;
   logic [11:0] walk_ff;
   logic [7:0]  first_ff;
   logic [7:0]  depth_ff;
   logic [2:0]  cnt_ff;
   logic [31:0] word_ff;
   logic        full_ff;

   logic        rsp_valid_ff;
   logic [31:0] rsp_bytes_ff;
   logic [2:0]  rsp_count_ff;
   logic [1:0]  rsp_status_ff;
   logic        rsp_last_ff;

   // memories
   logic [11:0] prefix_mem [lzw_vwd_pkg::DICT_WORDS];
   logic [7:0]  suffix_mem [lzw_vwd_pkg::DICT_WORDS];
   logic [7:0]  stack_mem  [lzw_vwd_pkg::STACK_DEPTH];
   logic [11:0] prefix_rd_ff;
   logic [7:0]  suffix_rd_ff;
   logic [7:0]  stack_rd_ff;

   // extraction datapath
   logic        quirk;
   logic [2:0]  shift;
   logic [4:0]  need;
   logic [11:0] mask;
   logic [23:0] shifted;
   logic [4:0]  adv;
   logic [1:0]  drop;
   logic [10:0] win_dist;

   // memory control
   logic        stk_we;
   logic [7:0]  stk_waddr;
   logic [7:0]  stk_wdata;
   logic        dict_we;
   logic        dict_re;
   logic        stk_re;
   logic        depth_full;
   logic        walk_is_byte;

   always_comb begin
      win_dist = 11'(lzw_vwd_pkg::WINDOW_BYTES) - {1'b0, window_ff};
      quirk    = {1'b0, window_ff} >= 11'(lzw_vwd_pkg::WINDOW_BYTES - 3);
      shift    = (quirk && after_clear_ff) ? win_dist[2:0] : first_bit_ff;
      need     = ((shift > first_bit_ff) ? {2'b0, shift} : {2'b0, first_bit_ff})
               + {1'b0, width_ff};
      mask     = 12'((13'd1 << width_ff) - 13'd1);
      shifted  = acc_ff >> shift;
      adv      = {2'b0, first_bit_ff} + {1'b0, width_ff};
      drop     = adv[4:3];
   end

   assign depth_full   = depth_ff >= 8'(lzw_vwd_pkg::STACK_DEPTH);
   assign walk_is_byte = walk_ff[11:8] == 4'd0;

   always_comb begin
      stk_we    = 1'b0;
      stk_waddr = depth_ff;
      stk_wdata = walk_ff[7:0];
      dict_re   = 1'b0;
      dict_we   = 1'b0;
      stk_re    = 1'b0;
      case (state_ff)
         S_DECODE: begin
            stk_we    = !after_clear_ff && code_ff != lzw_vwd_pkg::CODE_END
                        && code_ff != lzw_vwd_pkg::CODE_CLEAR
                        && {2'b0, code_ff} >= next_code_ff;
            stk_waddr = '0;
            stk_wdata = prev_char_ff;
         end
         S_WALK: begin
            stk_we    = walk_is_byte && !depth_full;
            stk_wdata = walk_ff[7:0];
            dict_re   = !walk_is_byte && !depth_full;
         end
         S_WREAD: begin
            stk_we    = 1'b1;
            stk_wdata = suffix_rd_ff;
         end
         S_UPDATE: dict_we = next_code_ff < 14'(lzw_vwd_pkg::DICT_LIMIT)
                             && next_code_ff < 14'(lzw_vwd_pkg::DICT_WORDS);
         S_POP:    stk_re  = cnt_ff != 3'd4 && depth_ff != 8'd0;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[stk_waddr] <= stk_wdata;
      end
      if (stk_re) begin
         stack_rd_ff <= stack_mem[depth_ff - 8'd1];
      end
   end

   always_ff @(posedge clock) begin
      if (dict_we) begin
         prefix_mem[next_code_ff[11:0]] <= prev_code_ff;
         suffix_mem[next_code_ff[11:0]] <= first_ff;
      end
      if (dict_re) begin
         prefix_rd_ff <= prefix_mem[walk_ff];
         suffix_rd_ff <= suffix_mem[walk_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         acc_ff         <= '0;
         held_ff        <= '0;
         first_bit_ff   <= '0;
         width_ff       <= lzw_vwd_pkg::FIRST_WIDTH;
         next_code_ff   <= lzw_vwd_pkg::FIRST_FREE;
         threshold_ff   <= lzw_vwd_pkg::FIRST_THRESHOLD;
         prev_code_ff   <= '0;
         prev_char_ff   <= '0;
         after_clear_ff <= 1'b0;
         window_ff      <= '0;
         stopped_ff     <= 1'b0;
         full_ff        <= 1'b0;
         depth_ff       <= '0;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  byte_ff  <= req_in_byte;
                  state_ff <= S_LOAD;
                  if (req_stream_start) begin
                     acc_ff         <= '0;
                     held_ff        <= '0;
                     first_bit_ff   <= '0;
                     width_ff       <= lzw_vwd_pkg::FIRST_WIDTH;
                     next_code_ff   <= lzw_vwd_pkg::FIRST_FREE;
                     threshold_ff   <= lzw_vwd_pkg::FIRST_THRESHOLD;
                     prev_code_ff   <= '0;
                     prev_char_ff   <= '0;
                     after_clear_ff <= 1'b0;
                     window_ff      <= '0;
                     stopped_ff     <= 1'b0;
                  end
               end
            end
            S_LOAD: begin
               if (stopped_ff) begin
                  state_ff <= S_IDLE;
               end else begin
                  if (held_ff <= 5'd16) begin
                     acc_ff  <= acc_ff | ({16'b0, byte_ff} << held_ff);
                     held_ff <= held_ff + 5'd8;
                  end
                  state_ff <= S_EXTRACT;
               end
            end
            S_EXTRACT: begin
               if (held_ff < need) begin
                  state_ff <= S_IDLE;
               end else begin
                  code_ff      <= shifted[11:0] & mask;
                  acc_ff       <= acc_ff >> {drop, 3'b0};
                  held_ff      <= held_ff - {drop, 3'b0};
                  first_bit_ff <= adv[2:0];
                  window_ff    <= (quirk ? 10'd0 : window_ff) + {8'b0, drop};
                  state_ff     <= S_DECODE;
               end
            end
            S_DECODE: begin
               depth_ff <= '0;
               cnt_ff   <= '0;
               word_ff  <= '0;
               full_ff  <= 1'b0;
               if (after_clear_ff) begin
                  after_clear_ff <= 1'b0;
                  prev_code_ff   <= code_ff;
                  prev_char_ff   <= code_ff[7:0];
                  rsp_bytes_ff   <= {24'b0, code_ff[7:0]};
                  rsp_count_ff   <= 3'd1;
                  rsp_status_ff  <= lzw_vwd_pkg::ST_DATA;
                  rsp_last_ff    <= 1'b1;
                  rsp_valid_ff   <= 1'b1;
                  state_ff       <= S_OUT;
               end else if (code_ff == lzw_vwd_pkg::CODE_END) begin
                  stopped_ff    <= 1'b1;
                  rsp_bytes_ff  <= '0;
                  rsp_count_ff  <= '0;
                  rsp_status_ff <= lzw_vwd_pkg::ST_END;
                  rsp_last_ff   <= 1'b1;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= S_OUT;
               end else if (code_ff == lzw_vwd_pkg::CODE_CLEAR) begin
                  width_ff       <= lzw_vwd_pkg::FIRST_WIDTH;
                  next_code_ff   <= lzw_vwd_pkg::FIRST_FREE;
                  threshold_ff   <= lzw_vwd_pkg::FIRST_THRESHOLD;
                  after_clear_ff <= 1'b1;
                  state_ff       <= S_IDLE;
               end else begin
                  // unknown code: previous char goes first, walk previous code
                  if (stk_we) begin
                     depth_ff <= 8'd1;
                     walk_ff  <= prev_code_ff;
                  end else begin
                     walk_ff  <= code_ff;
                  end
                  state_ff <= S_WALK;
               end
            end
            S_WALK: begin
               if (depth_full) begin
                  stopped_ff    <= 1'b1;
                  rsp_bytes_ff  <= '0;
                  rsp_count_ff  <= '0;
                  rsp_status_ff <= lzw_vwd_pkg::ST_OVERFLOW;
                  rsp_last_ff   <= 1'b1;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= S_OUT;
               end else if (walk_is_byte) begin
                  first_ff     <= walk_ff[7:0];
                  prev_char_ff <= walk_ff[7:0];
                  depth_ff     <= depth_ff + 8'd1;
                  state_ff     <= S_UPDATE;
               end else begin
                  state_ff <= S_WREAD;
               end
            end
            S_WREAD: begin
               depth_ff <= depth_ff + 8'd1;
               walk_ff  <= prefix_rd_ff;
               state_ff <= S_WALK;
            end
            S_UPDATE: begin
               if (next_code_ff >= 14'(lzw_vwd_pkg::DICT_LIMIT)) begin
                  full_ff    <= 1'b1;
                  stopped_ff <= 1'b1;
               end else begin
                  next_code_ff <= next_code_ff + 14'd1;
                  prev_code_ff <= code_ff;
                  if (next_code_ff + 14'd1 >= {1'b0, threshold_ff}
                      && width_ff < lzw_vwd_pkg::MAX_WIDTH) begin
                     width_ff     <= width_ff + 4'd1;
                     threshold_ff <= threshold_ff << 1;
                  end
               end
               state_ff <= S_POP;
            end
            S_POP: begin
               if (stk_re) begin
                  depth_ff <= depth_ff - 8'd1;
                  state_ff <= S_PACK;
               end else begin
                  rsp_bytes_ff  <= word_ff;
                  rsp_count_ff  <= cnt_ff;
                  rsp_status_ff <= (depth_ff == 8'd0 && full_ff) ?
                                   lzw_vwd_pkg::ST_FULL : lzw_vwd_pkg::ST_DATA;
                  rsp_last_ff   <= depth_ff == 8'd0;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= S_OUT;
               end
            end
            S_PACK: begin
               word_ff  <= word_ff | ({24'b0, stack_rd_ff} << {cnt_ff[1:0], 3'b0});
               cnt_ff   <= cnt_ff + 3'd1;
               state_ff <= S_POP;
            end
            S_OUT: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  cnt_ff       <= '0;
                  word_ff      <= '0;
                  state_ff     <= rsp_last_ff ? S_IDLE : S_POP;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall       = state_ff != S_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_bytes   = rsp_bytes_ff;
   assign rsp_byte_count  = rsp_count_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

/* src/lzw_vwd_checker.sv */
// ----------------------------------------------------------------------------
// lzw_vwd_assertions
// Port-level checks for the variable-width LZW decoder.
// ----------------------------------------------------------------------------
module lzw_vwd_assertions (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_out_bytes,
   input logic [2:0]  rsp_byte_count,
   input logic [1:0]  rsp_status,
   input logic        rsp_last_of_run
);

   // hold a stalled word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_bytes)
      && $stable(rsp_byte_count))
      else $error("stalled result word changed");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while a result waits");

   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_byte_count <= 3'd4)
      else $error("byte count above four");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != lzw_vwd_pkg::ST_DATA |-> rsp_last_of_run)
      else $error("status word not last of run");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == lzw_vwd_pkg::ST_END
                    || rsp_status == lzw_vwd_pkg::ST_OVERFLOW)
      |-> rsp_byte_count == 3'd0 && rsp_out_bytes == 32'd0)
      else $error("end or overflow word carries data");

endmodule

bind lzw_variable_width_decoder lzw_vwd_assertions u_lzw_vwd_assertions (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_bytes   (rsp_out_bytes),
   .rsp_byte_count  (rsp_byte_count),
   .rsp_status      (rsp_status),
   .rsp_last_of_run (rsp_last_of_run)
);
